// ===== rtl/core/mavt_pkg.sv =====
`default_nettype none

package mavt_pkg;

    // Encoder resolution: counts per turn is 2^ANGLE_BITS (valid range 8..20)
    localparam int ANGLE_BITS = 14;

    // Field widths on the ports
    localparam int FUNC_W    = 2;
    localparam int SAMPLE_W  = 14;
    localparam int TIME_W    = 32;
    localparam int LAP_W     = 14;
    localparam int FULL_W    = 46;
    localparam int VEL_W     = 32;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 96;
    localparam int M_TUSER_W = 1;
    localparam int M_PAD_W   = M_TDATA_W - LAP_W - FULL_W - VEL_W;

    // Function codes carried on s_tuser
    localparam logic [FUNC_W-1:0] FUNC_INIT   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_UPDATE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_VEL    = 2'd2;

    // Velocity datapath widths
    localparam int MAG_W  = TIME_W + ANGLE_BITS;  // |turn delta * 2^AB + angle delta|
    localparam int N_W    = MAG_W + 1;            // signed count delta
    localparam int US_W   = 20;                   // width of the 1e6 scale constant
    localparam int PROD_W = MAG_W + US_W;         // scaled dividend
    localparam int HI_W   = PROD_W - VEL_W;       // dividend bits above the quotient
    localparam int CMP_W  = (HI_W > TIME_W) ? HI_W : TIME_W;
    localparam int US_CNT_W   = $clog2(US_W);
    localparam int QUOT_CNT_W = $clog2(VEL_W);

    localparam logic [US_W-1:0]   US_PER_S   = US_W'(1000000);
    localparam logic [TIME_W-1:0] DEFAULT_DT = TIME_W'(1000);
    localparam logic [VEL_W-1:0]  VEL_MAX    = {1'b0, {(VEL_W-1){1'b1}}};
    localparam logic [VEL_W-1:0]  VEL_MIN    = {1'b1, {(VEL_W-1){1'b0}}};

    // Lap bits that also show in the low bits of the full angle
    localparam int LAP_CMP_W = (ANGLE_BITS < LAP_W) ? ANGLE_BITS : LAP_W;

    // Turn count times 2^AB plus the lap angle, wrapped to the field width
    function automatic logic [FULL_W-1:0] full_angle_f(input logic [TIME_W-1:0] tc,
                                                       input logic [ANGLE_BITS-1:0] ang);
        logic [2*TIME_W-1:0] tcx;
        tcx = {{TIME_W{tc[TIME_W-1]}}, tc};
        return {tcx[FULL_W-ANGLE_BITS-1:0], ang};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mavt_mul.sv =====
`default_nettype none

// Radix-2 serial multiply by the 1e6 scale constant, one constant bit per cycle
module mavt_mul import mavt_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [MAG_W-1:0]  mcand,
    output logic              done,
    output logic [PROD_W-1:0] product
);

    logic                busy_reg;
    logic                done_reg;
    logic [US_CNT_W-1:0] cnt_reg;
    logic [US_W-1:0]     digit_reg;
    logic [MAG_W-1:0]    mcand_reg;
    logic [PROD_W-1:0]   acc_reg;
    logic [PROD_W-1:0]   acc_next;

    // Horner step, constant bits taken MSB first
    always_comb begin
        acc_next = {acc_reg[PROD_W-2:0], 1'b0}
                 + (digit_reg[US_W-1] ? PROD_W'(mcand_reg) : PROD_W'(0));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg  <= 1'b1;
                cnt_reg   <= US_CNT_W'(US_W - 1);
                digit_reg <= US_PER_S;
                mcand_reg <= mcand;
                acc_reg   <= '0;
            end else if (busy_reg) begin
                acc_reg   <= acc_next;
                digit_reg <= {digit_reg[US_W-2:0], 1'b0};
                cnt_reg   <= cnt_reg - US_CNT_W'(1);
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

`default_nettype wire

// ===== rtl/core/mavt_div.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle; flags quotients of 2^32 or more
module mavt_div import mavt_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [PROD_W-1:0] dividend,
    input  logic [TIME_W-1:0] divisor,
    output logic              done,
    output logic              sat,
    output logic [VEL_W-1:0]  quot
);

    typedef enum logic [1:0] {D_IDLE, D_CHECK, D_RUN} dstate_t;

    dstate_t               state_reg;
    logic                  done_reg;
    logic                  sat_reg;
    logic [QUOT_CNT_W-1:0] cnt_reg;
    logic [CMP_W-1:0]      hi_reg;
    logic [VEL_W-1:0]      lo_reg;
    logic [TIME_W-1:0]     dsr_reg;
    logic [TIME_W-1:0]     trial;
    logic                  fits;

    // Partial remainder stays below the divisor (< 2^31) once the check passes
    always_comb begin
        trial = {hi_reg[TIME_W-2:0], lo_reg[VEL_W-1]};
        fits  = (trial >= dsr_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                D_IDLE: begin
                    if (start) begin
                        hi_reg    <= CMP_W'(dividend[PROD_W-1:VEL_W]);
                        lo_reg    <= dividend[VEL_W-1:0];
                        dsr_reg   <= divisor;
                        state_reg <= D_CHECK;
                    end
                end
                D_CHECK: begin
                    // high part at or above the divisor: quotient overflows
                    if (hi_reg >= CMP_W'(dsr_reg)) begin
                        sat_reg   <= 1'b1;
                        done_reg  <= 1'b1;
                        state_reg <= D_IDLE;
                    end else begin
                        sat_reg   <= 1'b0;
                        cnt_reg   <= QUOT_CNT_W'(VEL_W - 1);
                        state_reg <= D_RUN;
                    end
                end
                D_RUN: begin
                    hi_reg  <= fits ? CMP_W'(trial - dsr_reg) : CMP_W'(trial);
                    lo_reg  <= {lo_reg[VEL_W-2:0], fits};
                    cnt_reg <= cnt_reg - QUOT_CNT_W'(1);
                    if (cnt_reg == '0) begin
                        done_reg  <= 1'b1;
                        state_reg <= D_IDLE;
                    end
                end
                default: state_reg <= D_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign sat  = sat_reg;
    assign quot = lo_reg;

endmodule

`default_nettype wire

// ===== rtl/core/multiturn_angle_velocity_tracker.sv =====
// Multiturn angle and velocity tracker for a single-turn absolute encoder of
// 2^ANGLE_BITS counts per turn. s_tuser selects the function: 0 starts tracking
// from the sample, 1 takes a new sample and counts a turn when the angle jumps
// by more than 0.8 turn, 2 reports the velocity in counts per second since the
// previous velocity item (or start), saturated to 32 bits, with 1000 us used
// when the elapsed time is zero or negative. Every item returns one result
// with the lap angle and the full multiturn angle. Functions 0, 1 and 3 give
// their result in the cycle after the item is taken; function 2 steps through
// a prepare stage, an absolute-value stage, a serial multiply by 1e6 and a
// restoring divide by the elapsed time (the divide stops after its range check
// when the quotient overflows), then waits for the output register. One item is
// in work at a time; a new item is taken once the output register is free or
// being read.
`default_nettype none

module multiturn_angle_velocity_tracker import mavt_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // angle_sample[13:0], timestamp_us[45:14]
    input  logic [FUNC_W-1:0]    s_tuser,   // func[1:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // lap_angle[13:0], full_angle[59:14],
                                            // velocity[91:60]
    output logic [M_TUSER_W-1:0] m_tuser    // velocity_valid[0]
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_PREP, ST_ABS, ST_MUL, ST_DIV, ST_DONE
    } state_t;

    state_t state_reg;

    // Tracker state
    logic [ANGLE_BITS-1:0] last_angle_reg, last_angle_next;
    logic [TIME_W-1:0]     last_time_reg,  last_time_next;
    logic [TIME_W-1:0]     turn_count_reg, turn_count_next;
    logic [ANGLE_BITS-1:0] ref_angle_reg,  ref_angle_next;
    logic [TIME_W-1:0]     ref_time_reg,   ref_time_next;
    logic [TIME_W-1:0]     ref_turn_reg,   ref_turn_next;

    // Velocity operands
    logic [TIME_W-1:0]     td_reg;
    logic [ANGLE_BITS:0]   ad_reg;
    logic [TIME_W-1:0]     dt_reg;
    logic [N_W-1:0]        n_reg;
    logic                  neg_reg;
    logic [MAG_W-1:0]      mag_reg;
    logic [TIME_W-1:0]     e_reg;
    logic                  mul_go_reg;
    logic                  div_go_reg;

    // Output register
    logic                  m_tvalid_reg;
    logic [LAP_W-1:0]      lap_reg;
    logic [FULL_W-1:0]     full_reg;
    logic [VEL_W-1:0]      vel_reg;
    logic                  vv_reg;

    logic                  accept;
    logic [FUNC_W-1:0]     func;
    logic [ANGLE_BITS-1:0] sample;
    logic [TIME_W-1:0]     stamp;
    logic [ANGLE_BITS:0]   d;
    logic [ANGLE_BITS:0]   d_neg;
    logic [ANGLE_BITS-1:0] d_abs;
    logic [ANGLE_BITS+2:0] d_x5;
    logic                  wrap;
    logic [N_W-1:0]        n_sum;
    logic [N_W-1:0]        n_neg;
    logic                  mul_done;
    logic [PROD_W-1:0]     product;
    logic                  div_done;
    logic                  div_sat;
    logic [VEL_W-1:0]      quot;
    logic                  big;
    logic [VEL_W-1:0]      vel_sat;

    assign s_tready = (state_reg == ST_IDLE) && (!m_tvalid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign func     = s_tuser;
    assign sample   = ANGLE_BITS'(s_tdata[SAMPLE_W-1:0]);
    assign stamp    = s_tdata[SAMPLE_W +: TIME_W];

    // Wrap detection: 5*|d| > 4 turns' worth of counts
    always_comb begin
        d     = {1'b0, sample} - {1'b0, last_angle_reg};
        d_neg = -d;
        d_abs = d[ANGLE_BITS] ? d_neg[ANGLE_BITS-1:0] : d[ANGLE_BITS-1:0];
        d_x5  = {3'b000, d_abs} + {1'b0, d_abs, 2'b00};
        wrap  = d_x5 > {3'b100, {ANGLE_BITS{1'b0}}};
    end

    // Tracker state update on an accepted item
    always_comb begin
        last_angle_next = last_angle_reg;
        last_time_next  = last_time_reg;
        turn_count_next = turn_count_reg;
        ref_angle_next  = ref_angle_reg;
        ref_time_next   = ref_time_reg;
        ref_turn_next   = ref_turn_reg;
        if (accept) begin
            unique case (func)
                FUNC_INIT: begin
                    last_angle_next = sample;
                    ref_angle_next  = sample;
                    last_time_next  = stamp;
                    ref_time_next   = stamp;
                    turn_count_next = '0;
                    ref_turn_next   = '0;
                end
                FUNC_UPDATE: begin
                    if (wrap) begin
                        turn_count_next = d[ANGLE_BITS] ? turn_count_reg + TIME_W'(1)
                                                        : turn_count_reg - TIME_W'(1);
                    end
                    last_angle_next = sample;
                    last_time_next  = stamp;
                end
                FUNC_VEL: begin
                    ref_angle_next = last_angle_reg;
                    ref_time_next  = last_time_reg;
                    ref_turn_next  = turn_count_reg;
                end
                default: ;
            endcase
        end
    end

    // Count delta and its magnitude
    always_comb begin
        n_sum = {td_reg[TIME_W-1], td_reg, {ANGLE_BITS{1'b0}}}
              + {{(N_W-ANGLE_BITS-1){ad_reg[ANGLE_BITS]}}, ad_reg};
        n_neg = -n_reg;
    end

    // Sign and saturation of the quotient
    always_comb begin
        big = div_sat || quot[VEL_W-1];
        if (neg_reg) begin
            vel_sat = big ? VEL_MIN : -quot;
        end else begin
            vel_sat = big ? VEL_MAX : quot;
        end
    end

    mavt_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_go_reg),
        .mcand   (mag_reg),
        .done    (mul_done),
        .product (product)
    );

    mavt_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_go_reg),
        .dividend (product),
        .divisor  (e_reg),
        .done     (div_done),
        .sat      (div_sat),
        .quot     (quot)
    );

    // Sequencer, tracker state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_tvalid_reg   <= 1'b0;
            mul_go_reg     <= 1'b0;
            div_go_reg     <= 1'b0;
            last_angle_reg <= '0;
            last_time_reg  <= '0;
            turn_count_reg <= '0;
            ref_angle_reg  <= '0;
            ref_time_reg   <= '0;
            ref_turn_reg   <= '0;
        end else begin
            mul_go_reg     <= 1'b0;
            div_go_reg     <= 1'b0;
            last_angle_reg <= last_angle_next;
            last_time_reg  <= last_time_next;
            turn_count_reg <= turn_count_next;
            ref_angle_reg  <= ref_angle_next;
            ref_time_reg   <= ref_time_next;
            ref_turn_reg   <= ref_turn_next;
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        if (func == FUNC_VEL) begin
                            td_reg    <= turn_count_reg - ref_turn_reg;
                            ad_reg    <= {1'b0, last_angle_reg} - {1'b0, ref_angle_reg};
                            dt_reg    <= last_time_reg - ref_time_reg;
                            state_reg <= ST_PREP;
                        end else begin
                            m_tvalid_reg <= 1'b1;
                            lap_reg      <= LAP_W'(last_angle_next);
                            full_reg     <= full_angle_f(turn_count_next, last_angle_next);
                            vel_reg      <= '0;
                            vv_reg       <= 1'b0;
                        end
                    end
                end
                ST_PREP: begin
                    n_reg     <= n_sum;
                    state_reg <= ST_ABS;
                end
                ST_ABS: begin
                    neg_reg    <= n_reg[N_W-1];
                    mag_reg    <= n_reg[N_W-1] ? n_neg[MAG_W-1:0] : n_reg[MAG_W-1:0];
                    e_reg      <= (dt_reg == '0 || dt_reg[TIME_W-1]) ? DEFAULT_DT : dt_reg;
                    mul_go_reg <= 1'b1;
                    state_reg  <= ST_MUL;
                end
                ST_MUL: begin
                    if (mul_done) begin
                        div_go_reg <= 1'b1;
                        state_reg  <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        lap_reg      <= LAP_W'(last_angle_reg);
                        full_reg     <= full_angle_f(turn_count_reg, last_angle_reg);
                        vel_reg      <= vel_sat;
                        vv_reg       <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, vel_reg, full_reg, lap_reg};
    assign m_tuser  = vv_reg;

endmodule

`default_nettype wire

// ===== rtl/core/mavt_checker.sv =====
`default_nettype none

module mavt_checker import mavt_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [FUNC_W-1:0]    s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [M_TUSER_W-1:0] m_tuser
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // No item is taken while a result is blocked
    a_no_take_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready && m_tvalid |-> m_tready)
        else $error("item taken while output blocked");

    // Initialize and update answer in the next cycle
    a_fast_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == FUNC_INIT || s_tuser == FUNC_UPDATE)
        |=> m_tvalid)
        else $error("missing result after initialize or update");

    // Velocity is zero without a fresh measurement
    a_vel_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[LAP_W+FULL_W +: VEL_W] == '0)
        else $error("velocity set without measurement");

    // Lap angle agrees with the low bits of the full angle
    a_lap_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[LAP_CMP_W-1:0] == m_tdata[LAP_W +: LAP_CMP_W])
        else $error("lap and full angle disagree");

endmodule

bind multiturn_angle_velocity_tracker mavt_checker u_mavt_checker (.*);

`default_nettype wire
